// ===== rtl/unaligned_word_access_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the unaligned word access unit
// Implication checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef UNALIGNED_WORD_ACCESS_UNIT_MACROS_SVH
`define UNALIGNED_WORD_ACCESS_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define UWAU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unaligned_word_access_unit: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define UWAU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unaligned_word_access_unit: next-cycle check failed");

`endif

// ===== rtl/uwau_pkg.sv =====
// ----------------------------------------------------------------------------
// uwau_pkg
// Shared widths, register map and request type of the unaligned word access
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package uwau_pkg;

    localparam int WORD_BYTES_DEF = 8;
    localparam int MEM_WORDS_DEF  = 1024;

    localparam int ADDR_W      = 13;
    localparam int SIZE_W      = 4;
    localparam int DATA_W      = 64;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 64;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] REG_BIG_ENDIAN = 2'd0;

    // Fraction bits of the reciprocal constants used to split addresses.
    localparam int RECIP_K = 16;
    localparam int PROD_W  = ADDR_W + RECIP_K + 1;

    typedef struct packed {
        logic              is_write;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] data;
    } t_req;

endpackage

`default_nettype wire

// ===== rtl/unaligned_word_access_unit.sv =====
// ----------------------------------------------------------------------------
// unaligned_word_access_unit
// A read is accepted and its result is offered after the split, read and merge
// states; the unit takes its next transaction only once it is back in idle.
// The steps are the two-step reciprocal split of the address into word
// and lane, one read of both words, and up to two writes through one port.
// After reset the store is cleared word by word before the first accept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unaligned_word_access_unit_macros.svh"

module unaligned_word_access_unit
    import uwau_pkg::*;
#(
    parameter int WORD_BYTES = WORD_BYTES_DEF,
    parameter int MEM_WORDS  = MEM_WORDS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // byte_address[12:0], access_size[16:13], write_data[80:17], zero pad
    input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type[0]
    input  wire  [0:0]             s_axis_tuser,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // read_data[63:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [APB_AW-1:0]      paddr,
    input  wire  [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int DW = 8 * WORD_BYTES;
    localparam int LW = $clog2(WORD_BYTES);
    localparam int IW = LW + 1;
    localparam int AW = $clog2(MEM_WORDS);
    localparam int WIN = 2 * WORD_BYTES;
    localparam int RECIP_WB = (1 << RECIP_K) / WORD_BYTES;
    localparam int RECIP_MW = (1 << RECIP_K) / MEM_WORDS;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_Q1    = 4'd2;
    localparam logic [3:0] S_Q2    = 4'd3;
    localparam logic [3:0] S_M1    = 4'd4;
    localparam logic [3:0] S_M2    = 4'd5;
    localparam logic [3:0] S_MERGE = 4'd6;
    localparam logic [3:0] S_WR0   = 4'd7;
    localparam logic [3:0] S_WR1   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [AW-1:0]     r_clr;
    t_req              r_req;
    logic [ADDR_W-1:0] r_q;
    logic [ADDR_W-1:0] r_word_raw;
    logic [LW-1:0]     r_lane;
    logic [AW-1:0]     r_w0, r_w1;
    logic [DW-1:0]     r_wd0, r_wd1;
    logic              r_touch0, r_touch1;
    logic [DW-1:0]     r_rdata;
    logic [DW-1:0]     r_out_data;
    logic              r_out_valid;
    logic              r_big_endian;

    logic              in_accept;
    logic              out_load;
    logic              cfg_we;
    logic [ADDR_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [ADDR_W:0]   rem1;
    logic [PROD_W-1:0] q_mw;
    logic [ADDR_W:0]   rem2;
    logic [17:0]       rem2_x;
    logic [AW-1:0]     w0_c, w1_c;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DW-1:0]     ram_wdata;
    logic [DW-1:0]     rd0, rd1;
    logic [IW-1:0]     size_c;
    logic [IW-1:0]     lane_e;
    logic [7:0]        win  [WIN];
    logic [7:0]        nwin [WIN];
    logic [7:0]        dbyte [WORD_BYTES];
    logic [DW-1:0]     res_c, wd0_c, wd1_c;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_BIG_ENDIAN);
    assign prdata = (paddr == REG_BIG_ENDIAN) ? APB_DW'(r_big_endian) : '0;

    // Shared reciprocal multiplier: address by word size, then word by depth.
    assign mul_a = (r_state == S_Q1) ? r_req.addr : r_word_raw;
    assign mul_b = (r_state == S_Q1) ? PROD_W'(RECIP_WB) : PROD_W'(RECIP_MW);
    assign mul_p = PROD_W'(mul_a) * mul_b;

    assign rem1   = {1'b0, r_req.addr} - {1'b0, ADDR_W'(r_q * ADDR_W'(WORD_BYTES))};
    assign q_mw   = PROD_W'(r_q) * PROD_W'(MEM_WORDS);
    assign rem2   = {1'b0, r_word_raw} - {1'b0, q_mw[ADDR_W-1:0]};
    assign rem2_x = ({4'b0, rem2} >= 18'(MEM_WORDS)) ? ({4'b0, rem2} - 18'(MEM_WORDS))
                                                     : {4'b0, rem2};
    assign w0_c   = AW'(rem2_x);
    assign w1_c   = (w0_c == AW'(MEM_WORDS - 1)) ? '0 : w0_c + AW'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_w1;
        ram_wdata = r_wd1;
        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_WR0: begin
                ram_we    = r_touch0;
                ram_waddr = r_w0;
                ram_wdata = r_wd0;
            end
            S_WR1: begin
                ram_we = r_touch1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    uwau_ram #(
        .WIDTH (DW),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr0 (w0_c),
        .i_raddr1 (w1_c),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    assign size_c = (r_req.size > SIZE_W'(WORD_BYTES)) ? IW'(WORD_BYTES)
                                                       : IW'(r_req.size);
    assign lane_e = {1'b0, r_lane};

    // Two-word window in address order: window byte j is at byte address addr + j - lane.
    for (genvar j = 0; j < WIN; j++) begin : g_win
        localparam int K = j % WORD_BYTES;
        localparam int W = j / WORD_BYTES;
        logic [DW-1:0] src;
        logic [IW-1:0] off;
        logic [IW-1:0] sel;
        logic          hit;
        assign src = (W == 0) ? rd0 : rd1;
        assign win[j] = r_big_endian ? src[8*(WORD_BYTES-1-K) +: 8] : src[8*K +: 8];
        assign off = IW'(j) - lane_e;
        assign hit = (IW'(j) >= lane_e) && (IW'(j) < lane_e + size_c);
        assign sel = r_big_endian ? (size_c - IW'(1) - off) : off;
        assign nwin[j] = hit ? dbyte[sel[LW-1:0]] : win[j];
    end

    for (genvar i = 0; i < WORD_BYTES; i++) begin : g_lane
        logic [IW-1:0] pos;
        logic [IW-1:0] idx;
        assign dbyte[i] = r_req.data[8*i +: 8];
        assign pos = r_big_endian ? (size_c - IW'(1) - IW'(i)) : IW'(i);
        assign idx = lane_e + pos;
        assign res_c[8*i +: 8] = (IW'(i) < size_c) ? win[idx] : 8'h00;
        assign wd0_c[8*i +: 8] = r_big_endian ? nwin[WORD_BYTES-1-i] : nwin[i];
        assign wd1_c[8*i +: 8] = r_big_endian ? nwin[WIN-1-i] : nwin[WORD_BYTES+i];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   n_state = (r_clr == AW'(MEM_WORDS - 1)) ? S_IDLE : S_CLR;
            S_IDLE:  n_state = in_accept ? S_Q1 : S_IDLE;
            S_Q1:    n_state = S_Q2;
            S_Q2:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_MERGE;
            S_MERGE: n_state = r_req.is_write ? S_WR0 : S_OUT;
            S_WR0:   n_state = S_WR1;
            S_WR1:   n_state = S_IDLE;
            S_OUT:   n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_big_endian <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_we) begin
                r_big_endian <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req.is_write <= s_axis_tuser[0];
            r_req.addr     <= s_axis_tdata[12:0];
            r_req.size     <= s_axis_tdata[16:13];
            r_req.data     <= s_axis_tdata[80:17];
        end
        if (r_state == S_Q1 || r_state == S_M1) begin
            r_q <= mul_p[RECIP_K+ADDR_W-1:RECIP_K];
        end
        if (r_state == S_Q2) begin
            if (rem1 >= (ADDR_W + 1)'(WORD_BYTES)) begin
                r_word_raw <= r_q + ADDR_W'(1);
                r_lane     <= LW'(rem1 - (ADDR_W + 1)'(WORD_BYTES));
            end else begin
                r_word_raw <= r_q;
                r_lane     <= LW'(rem1);
            end
        end
        if (r_state == S_M2) begin
            r_w0 <= w0_c;
            r_w1 <= w1_c;
        end
        if (r_state == S_MERGE) begin
            r_rdata  <= res_c;
            r_wd0    <= wd0_c;
            r_wd1    <= wd1_c;
            r_touch0 <= (size_c != '0);
            r_touch1 <= (lane_e + size_c > IW'(WORD_BYTES));
        end
        if (out_load) begin
            r_out_data <= r_rdata;
        end
    end

    `UWAU_ASSERT_IMP(a_clear_blocks, i_clk, i_rst_n, r_state == S_CLR,
                     !s_axis_tready && !m_axis_tvalid)
    `UWAU_ASSERT_IMP(a_write_states, i_clk, i_rst_n, ram_we,
                     r_state == S_CLR || r_state == S_WR0 || r_state == S_WR1)
    `UWAU_ASSERT_NXT(a_write_no_result, i_clk, i_rst_n,
                     in_accept && s_axis_tuser[0] && !m_axis_tvalid, !m_axis_tvalid)
    `UWAU_ASSERT_IMP(a_result_source, i_clk, i_rst_n, $rose(m_axis_tvalid),
                     $past(r_state == S_OUT))

endmodule

`default_nettype wire

// ===== rtl/uwau_ram.sv =====
// ----------------------------------------------------------------------------
// uwau_ram
// Generic synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module uwau_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire
